/* rtl/core/dbot_pkg.sv */
package dbot_pkg;

    // fixed field widths of the channel payloads
    localparam int OP_W       = 2;
    localparam int ID_W       = 8;
    localparam int DEPTH_W    = 16;
    localparam int BUCKET_W   = 6;

    // depth clamp and the bits that the bucket index is scaled from
    localparam int DEPTH_BITS = 12;
    localparam int DEPTH_MAX  = 4095;

    // defaults for the table geometry
    localparam int BUCKET_COUNT_DEF     = 64;
    localparam int SLOTS_PER_BUCKET_DEF = 8;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_DRAIN  = 2'd2
    } t_op;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [ID_W-1:0]     object_id;
        logic [DEPTH_W-1:0]  depth;
        logic [BUCKET_W-1:0] bucket;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0] object_id_out;
        logic            last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL_RD,
        S_INS_WR,
        S_DRN_CNT,
        S_DRN_RUN,
        S_DRN_TAIL
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic ins_wr;
        logic drn_start;
        logic issue;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_clear;
        logic in_insert;
        logic in_drain;
        logic is_drain;
        logic fill_zero;
        logic can_issue;
        logic last_issue;
    } t_dp_sts;

endpackage

/* rtl/core/dbot_ram.sv */
module dbot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/dbot_ctrl.sv */
module dbot_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dbot_pkg::t_dp_sts i_sts,
    output dbot_pkg::t_dp_cmd o_cmd
);

    import dbot_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load  = 1'b1;
                    o_cmd.clear = i_sts.in_clear;
                    if (i_sts.in_insert || i_sts.in_drain) begin
                        n_state = S_FILL_RD;
                    end
                end
            end
            S_FILL_RD: begin
                n_state = i_sts.is_drain ? S_DRN_CNT : S_INS_WR;
            end
            S_INS_WR: begin
                o_cmd.ins_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_DRN_CNT: begin
                o_cmd.drn_start = 1'b1;
                n_state         = i_sts.fill_zero ? S_IDLE : S_DRN_RUN;
            end
            S_DRN_RUN: begin
                if (i_sts.can_issue) begin
                    o_cmd.issue = 1'b1;
                    if (i_sts.last_issue) begin
                        n_state = S_DRN_TAIL;
                    end
                end
            end
            S_DRN_TAIL: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/dbot_dp.sv */
module dbot_dp #(
    parameter int BUCKET_COUNT     = 64,
    parameter int SLOTS_PER_BUCKET = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dbot_pkg::t_in_item  i_in_data,
    input  dbot_pkg::t_dp_cmd   i_cmd,
    output dbot_pkg::t_dp_sts   o_sts,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output dbot_pkg::t_out_item o_out_data
);

    import dbot_pkg::*;

    localparam int BKT_W    = $clog2(BUCKET_COUNT);
    localparam int SLOT_W   = $clog2(SLOTS_PER_BUCKET);
    localparam int CNT_W    = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int SLOT_N   = BUCKET_COUNT * SLOTS_PER_BUCKET;
    localparam int ADDR_W   = $clog2(SLOT_N);
    localparam int PROD_W   = DEPTH_BITS + $clog2(BUCKET_COUNT + 1);
    localparam int BKT_IN_N = 2 ** BUCKET_W;

    // drain bucket number folded into range
    typedef logic [BKT_IN_N-1:0][BKT_W-1:0] t_mod_tab;

    function automatic t_mod_tab mod_tab_build();
        t_mod_tab tab;
        for (int i = 0; i < BKT_IN_N; i++) begin
            tab[i] = BKT_W'(i % BUCKET_COUNT);
        end
        return tab;
    endfunction

    localparam t_mod_tab MOD_TAB = mod_tab_build();

    logic [DEPTH_BITS-1:0]   depth_clamped;
    logic [PROD_W-1:0]       prod;
    logic [BKT_W-1:0]        ins_bkt;
    logic [BKT_W-1:0]        drn_bkt;

    logic [BKT_W-1:0]        r_bkt;
    logic                    r_is_drain;
    logic [ID_W-1:0]         r_id;
    logic [BUCKET_COUNT-1:0] r_fill_vld;

    logic [CNT_W-1:0]        fill_rdata;
    logic [CNT_W-1:0]        fill_cur;
    logic                    fill_full;
    logic [CNT_W-1:0]        fill_next;
    logic [SLOT_W-1:0]       ins_pos;

    logic [CNT_W-1:0]        r_cnt;
    logic [SLOT_W-1:0]       r_k;
    logic                    r_rd_pend;
    logic                    r_rd_last;
    logic                    last_issue;

    logic [ADDR_W-1:0]       slot_base;
    logic [ADDR_W-1:0]       slot_waddr;
    logic [ADDR_W-1:0]       slot_raddr;
    logic [ID_W-1:0]         slot_rdata;

    logic                    r_out_vld;
    t_out_item               r_out;

    // bucket = clamped depth * count / 4096
    always_comb begin
        depth_clamped = (i_in_data.depth > DEPTH_W'(DEPTH_MAX))
                      ? DEPTH_BITS'(DEPTH_MAX) : i_in_data.depth[DEPTH_BITS-1:0];
        prod    = PROD_W'(depth_clamped) * PROD_W'(BUCKET_COUNT);
        ins_bkt = BKT_W'(prod >> DEPTH_BITS);
        drn_bkt = MOD_TAB[i_in_data.bucket];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_drain <= (i_in_data.operation == OP_DRAIN);
            r_bkt      <= (i_in_data.operation == OP_DRAIN) ? drn_bkt : ins_bkt;
            r_id       <= i_in_data.object_id;
        end
    end

    // per-bucket valid bits stand in for a zeroed fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_vld <= '0;
        end else if (i_cmd.clear) begin
            r_fill_vld <= '0;
        end else if (i_cmd.ins_wr) begin
            r_fill_vld[r_bkt] <= 1'b1;
        end
    end

    always_comb begin
        fill_cur  = r_fill_vld[r_bkt] ? fill_rdata : '0;
        fill_full = (fill_cur >= CNT_W'(SLOTS_PER_BUCKET));
        fill_next = fill_full ? fill_cur : fill_cur + CNT_W'(1);
        ins_pos   = fill_full ? SLOT_W'(SLOTS_PER_BUCKET - 1) : SLOT_W'(fill_cur);
    end

    dbot_ram #(
        .WIDTH (CNT_W),
        .DEPTH (BUCKET_COUNT)
    ) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ins_wr),
        .i_waddr (r_bkt),
        .i_wdata (fill_next),
        .i_raddr (r_bkt),
        .o_rdata (fill_rdata)
    );

    assign slot_base  = ADDR_W'(r_bkt) * ADDR_W'(SLOTS_PER_BUCKET);
    assign slot_waddr = slot_base + ADDR_W'(ins_pos);
    assign slot_raddr = slot_base + ADDR_W'(r_k);

    dbot_ram #(
        .WIDTH (ID_W),
        .DEPTH (SLOT_N)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ins_wr),
        .i_waddr (slot_waddr),
        .i_wdata (r_id),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    // drain walk
    assign last_issue = ((CNT_W'(r_k) + CNT_W'(1)) == r_cnt);

    always_ff @(posedge i_clk) begin
        if (i_cmd.drn_start) begin
            r_cnt <= fill_cur;
            r_k   <= '0;
        end else if (i_cmd.issue) begin
            r_k <= r_k + SLOT_W'(1);
        end
        if (i_cmd.issue) begin
            r_rd_last <= last_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.issue;
            if (r_rd_pend) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_pend) begin
            r_out.object_id_out <= slot_rdata;
            r_out.last          <= r_rd_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_comb begin
        o_sts            = '0;
        o_sts.in_clear   = (i_in_data.operation == OP_CLEAR);
        o_sts.in_insert  = (i_in_data.operation == OP_INSERT) && (i_in_data.object_id != '0);
        o_sts.in_drain   = (i_in_data.operation == OP_DRAIN);
        o_sts.is_drain   = r_is_drain;
        o_sts.fill_zero  = (fill_cur == '0);
        o_sts.can_issue  = !r_rd_pend && (!r_out_vld || i_out_ready);
        o_sts.last_issue = last_issue;
    end

endmodule

/* rtl/core/depth_bucket_ordering_table.sv */
// channel   direction  handshake                  beat
// in        input      i_in_valid / o_in_ready    t_in_item: operation, object_id, depth, bucket
// out       output     o_out_valid / i_out_ready  t_out_item: object_id_out, last
//
// clear and ignored beats are taken in the idle state; an insert reads the fill count, then writes
// a drain reads the fill count, then walks the ids: each id is one slot memory read followed by a
// load into the output register, and the walk holds while that register is stalled
// input is taken again as soon as the drain walk ends, even if the last id still waits
// i_rst_n is synchronous, active low; no clearing pass is needed after reset
module depth_bucket_ordering_table #(
    parameter int BUCKET_COUNT     = dbot_pkg::BUCKET_COUNT_DEF,
    parameter int SLOTS_PER_BUCKET = dbot_pkg::SLOTS_PER_BUCKET_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dbot_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dbot_pkg::t_out_item o_out_data
);

    import dbot_pkg::*;

    // command and status between the sequencer and the table datapath
    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer: accepts beats, walks insert and drain steps
    dbot_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: bucket index, fill counts, slot memory and the output register
    dbot_dp #(
        .BUCKET_COUNT     (BUCKET_COUNT),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

import dbot_pkg::*;

// copy of the ordering table kept by the testbench, plus the ids a drain should give
class ordering_table_model;
    localparam int NUM_BUCKETS = BUCKET_COUNT_DEF;
    localparam int NUM_SLOTS   = SLOTS_PER_BUCKET_DEF;

    logic [ID_W-1:0] slot_mem [NUM_BUCKETS*NUM_SLOTS];
    logic [3:0]      fill_cnt [NUM_BUCKETS];
    t_out_item       drained_ids_q [$];
    int unsigned     fail_count;

    function new();
        foreach (slot_mem[k]) slot_mem[k] = '0;
        foreach (fill_cnt[k]) fill_cnt[k] = '0;
        fail_count = 0;
    endfunction

    // accepted input beat: update the table and queue the ids a drain reads out
    function void note_command(t_in_item cmd);
        logic [DEPTH_BITS-1:0] clamped;
        logic [BUCKET_W-1:0]   bkt;
        int                    pos;
        t_out_item             exp_id;
        case (cmd.operation)
            OP_CLEAR: begin
                foreach (fill_cnt[k]) fill_cnt[k] = '0;
            end
            OP_INSERT: begin
                if (cmd.object_id != '0) begin
                    clamped = (cmd.depth > DEPTH_MAX) ? DEPTH_BITS'(DEPTH_MAX)
                                                      : cmd.depth[DEPTH_BITS-1:0];
                    bkt = clamped[DEPTH_BITS-1 -: BUCKET_W];
                    pos = fill_cnt[bkt];
                    if (pos >= NUM_SLOTS) begin
                        pos = NUM_SLOTS - 1;
                    end else begin
                        fill_cnt[bkt] = fill_cnt[bkt] + 1'b1;
                    end
                    slot_mem[bkt*NUM_SLOTS + pos] = cmd.object_id;
                end
            end
            OP_DRAIN: begin
                bkt = cmd.bucket;
                for (int k = 0; k < fill_cnt[bkt]; k++) begin
                    exp_id.object_id_out = slot_mem[bkt*NUM_SLOTS + k];
                    exp_id.last          = (k + 1 == fill_cnt[bkt]);
                    drained_ids_q.push_back(exp_id);
                end
            end
            default: ;
        endcase
    endfunction

    // accepted output beat against the oldest expected id
    function void check_drained_id(t_out_item got);
        t_out_item exp_id;
        if (drained_ids_q.size() == 0) begin
            $error("drained id %0d with last %0b arrived with nothing expected",
                   got.object_id_out, got.last);
            fail_count++;
            return;
        end
        exp_id = drained_ids_q.pop_front();
        if (got.object_id_out !== exp_id.object_id_out) begin
            $error("object_id_out: expected %0d, got %0d",
                   exp_id.object_id_out, got.object_id_out);
            fail_count++;
        end
        if (got.last !== exp_id.last) begin
            $error("last: expected %0b, got %0b", exp_id.last, got.last);
            fail_count++;
        end
    endfunction
endclass

module tb;

    // operation code that the block must ignore
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_BEATS = 305;
    localparam int HOLD_CYCLES  = 300;      // long output stall to back the block up
    localparam int TAIL_CYCLES  = 40;       // longer than the slowest drain walk
    localparam int CYCLE_LIMIT  = 400000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    ordering_table_model order_tbl = new();

    // shared between the sender and the receiver
    bit quiet    = 1'b0;    // no idling on either side while set
    bit hold_req = 1'b0;    // asks the receiver for one long stall

    logic [BUCKET_W-1:0] hot_bkt [3];
    int unsigned         cycle_cnt = 0;

    depth_bucket_ordering_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL depth_bucket_ordering_table");
            $finish;
        end
    end

    // output side: sample at the rising edge, check every accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            order_tbl.check_drained_id(o_out_data);
        end
    end

    // output ready: random stalls, a quiet stretch, and one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req    = 1'b0;
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_out_ready = quiet || ($urandom_range(99) >= 21);
        end
    end

    // random idle cycles ahead of a beat; valid only drops when a gap is taken
    task automatic sender_gap();
        while (!quiet && $urandom_range(99) < 21) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
    endtask

    // offer one beat from a falling edge and hold it until accepted
    task automatic push_command(input t_in_item cmd);
        sender_gap();
        i_in_data  = cmd;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        order_tbl.note_command(cmd);
        @(negedge i_clk);
    endtask

    task automatic issue(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                         input logic [DEPTH_W-1:0] depth, input logic [BUCKET_W-1:0] bkt);
        t_in_item cmd;
        cmd.operation = op;
        cmd.object_id = id;
        cmd.depth     = depth;
        cmd.bucket    = bkt;
        push_command(cmd);
    endtask

    // random beat: inserts and drains mostly aimed at a few hot buckets so that
    // they fill, overflow and give long drains; unused fields carry random bits
    function automatic t_in_item random_command();
        t_in_item    cmd;
        int unsigned r;
        logic [BUCKET_W-1:0] hb;
        cmd.object_id = ID_W'($urandom);
        cmd.depth     = DEPTH_W'($urandom);
        cmd.bucket    = BUCKET_W'($urandom);
        hb            = hot_bkt[$urandom_range(2)];
        r = $urandom_range(99);
        if (r < 2) begin
            cmd.operation = OP_CLEAR;
        end else if (r < 59) begin
            cmd.operation = OP_INSERT;
            cmd.object_id = ($urandom_range(99) < 6) ? '0 : ID_W'($urandom_range(1, 255));
            r = $urandom_range(99);
            if (r < 70) begin
                if (hb == BUCKET_W'(BUCKET_COUNT_DEF - 1) && $urandom_range(1) == 1) begin
                    cmd.depth = DEPTH_W'($urandom_range(DEPTH_MAX + 1, 65535));
                end else begin
                    cmd.depth = DEPTH_W'(hb * 64 + $urandom_range(63));
                end
            end else if (r < 90) begin
                cmd.depth = DEPTH_W'($urandom);
            end else begin
                case ($urandom_range(3))
                    0: cmd.depth = '0;
                    1: cmd.depth = DEPTH_W'(DEPTH_MAX);
                    2: cmd.depth = DEPTH_W'(DEPTH_MAX + 1);
                    default: cmd.depth = '1;
                endcase
            end
        end else if (r < 95) begin
            cmd.operation = OP_DRAIN;
            if ($urandom_range(99) < 70) cmd.bucket = hb;
        end else begin
            cmd.operation = OP_UNUSED;
        end
        return cmd;
    endfunction

    initial begin
        t_in_item    cmd;
        int unsigned counted;

        // synchronous reset, released on a falling edge
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty drain straight after reset
        issue(OP_DRAIN,  8'h3c, 16'h1234, 6'd0);
        // extremes of id and of the lowest bucket
        issue(OP_INSERT, 8'hff, 16'd0,    6'h3f);
        issue(OP_INSERT, 8'h01, 16'd63,   6'h2a);
        issue(OP_DRAIN,  8'h00, 16'hffff, 6'd0);
        // depths at and past the clamp all land in the top bucket
        issue(OP_INSERT, 8'h5a, 16'hffff, 6'd0);
        issue(OP_INSERT, 8'ha5, 16'd4096, 6'd0);
        issue(OP_INSERT, 8'h33, 16'd4095, 6'd0);
        // id zero means no object
        issue(OP_INSERT, 8'h00, 16'd64,   6'd0);
        issue(OP_DRAIN,  8'hff, 16'h0000, 6'd1);
        // unused operation code
        issue(OP_UNUSED, 8'h81, 16'd128,  6'd2);
        // neighbour of the bucket about to overflow, must survive the overflow
        issue(OP_INSERT, 8'h77, DEPTH_W'(6 * 64), 6'd0);
        // nine inserts into a bucket of eight: the last one replaces slot seven
        for (int k = 0; k < 9; k++) begin
            issue(OP_INSERT, ID_W'(16 + k), DEPTH_W'(5 * 64 + k * 7), 6'h15);
        end
        issue(OP_DRAIN,  8'h00, 16'h0000, 6'd5);
        issue(OP_DRAIN,  8'h00, 16'h0000, 6'd6);
        issue(OP_DRAIN,  8'h00, 16'h0000, 6'd63);
        // clear empties everything
        issue(OP_CLEAR,  8'haa, 16'h5555, 6'h2a);
        issue(OP_DRAIN,  8'h00, 16'h0000, 6'd63);

        // random part
        hot_bkt[0] = BUCKET_W'($urandom_range(BUCKET_COUNT_DEF - 1));
        hot_bkt[1] = BUCKET_W'($urandom_range(BUCKET_COUNT_DEF - 1));
        hot_bkt[2] = BUCKET_W'(BUCKET_COUNT_DEF - 1);
        counted = 0;
        while (counted < RANDOM_BEATS) begin
            // one long receiver stall while the sender keeps offering
            if (counted == 60) hold_req = 1'b1;
            // a stretch with no idling on either side
            quiet = (counted >= 180 && counted < 240);
            cmd = random_command();
            push_command(cmd);
            counted++;
        end
        quiet      = 1'b0;
        i_in_valid = 1'b0;

        // drain whatever is still owed, then let the block settle
        while (order_tbl.drained_ids_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (order_tbl.fail_count == 0) begin
            $display("PASS depth_bucket_ordering_table");
        end else begin
            $display("FAIL depth_bucket_ordering_table");
        end
        $finish;
    end

endmodule
